// ===== hdl/skt_pkg.sv =====
package skt_pkg;

  // Fixed field widths
  localparam int KEY_W   = 32;
  localparam int PRICE_W = 32;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 3;
  localparam int CMD_W   = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISSING = 3'd4;

  // Operation applied by every cell in the same cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_e;

  // Control broadcast from the sequencer to the cell row
  typedef struct packed {
    cell_op_e                   op;
    logic                       cmp;
    logic signed [KEY_W-1:0]    key;
    logic        [PRICE_W-1:0]  price;
    logic        [CNT_W-1:0]    count;
  } cell_ctl_t;

endpackage

// ===== hdl/skt_cell.sv =====
module skt_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk_i,
  input  skt_pkg::cell_ctl_t              ctl_i,
  input  logic signed [skt_pkg::KEY_W-1:0]   prev_key_i,
  input  logic        [skt_pkg::PRICE_W-1:0] prev_price_i,
  input  logic                            prev_upper_i,
  input  logic signed [skt_pkg::KEY_W-1:0]   next_key_i,
  input  logic        [skt_pkg::PRICE_W-1:0] next_price_i,
  input  logic signed [skt_pkg::KEY_W-1:0]   head_key_i,
  input  logic        [skt_pkg::PRICE_W-1:0] head_price_i,
  output logic signed [skt_pkg::KEY_W-1:0]   key_o,
  output logic        [skt_pkg::PRICE_W-1:0] price_o,
  output logic                            upper_o,
  output logic                            eq_o
);
  import skt_pkg::*;

  logic signed [KEY_W-1:0]   key_q, key_d;
  logic        [PRICE_W-1:0] price_q, price_d;
  logic                      upper_q, past_q, eq_q;
  logic                      occ, gt, eq, tail;

  // Compare the held entry against the broadcast key
  always_comb begin
    occ  = CNT_W'(IDX) < ctl_i.count;
    tail = CNT_W'(IDX + 1) == ctl_i.count;
    gt   = key_q > ctl_i.key;
    eq   = occ && (key_q == ctl_i.key);
  end

  // Capture position flags during the compare cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp) begin
      upper_q <= !occ || gt;
      past_q  <= occ && (gt || eq);
      eq_q    <= eq;
    end
  end

  // Choose the next entry: shift up, shift down, rotate or hold
  always_comb begin
    key_d   = key_q;
    price_d = price_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (upper_q) begin
          if (prev_upper_i) begin
            key_d   = prev_key_i;
            price_d = prev_price_i;
          end else begin
            key_d   = ctl_i.key;
            price_d = ctl_i.price;
          end
        end
      end
      OP_REMOVE: begin
        if (past_q) begin
          key_d   = next_key_i;
          price_d = next_price_i;
        end
      end
      OP_ROTATE: begin
        if (tail) begin
          key_d   = head_key_i;
          price_d = head_price_i;
        end else begin
          key_d   = next_key_i;
          price_d = next_price_i;
        end
      end
      default: begin
        key_d   = key_q;
        price_d = price_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    price_q <= price_d;
  end

  assign key_o   = key_q;
  assign price_o = price_q;
  assign upper_o = upper_q;
  assign eq_o    = eq_q;

endmodule

// ===== hdl/sorted_key_table.sv =====
// Sorted key table: holds up to DEPTH entries (signed key, price in cents) in
// ascending key order in a row of cells, one entry per cell. Commands are
// taken one at a time. Insert, remove and search go from request to result
// by accepting it, comparing in every cell, then shifting the row and loading
// the result register; the next request is taken in the cycle after that load.
// A non-empty list request then walks the row, which rotates by one cell per
// result and is back in its original order at the end. An output stall holds
// the row and the result register until the pending result is taken.
module sorted_key_table #(
  parameter int DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [skt_pkg::CMD_W-1:0]    command_i,
  input  logic signed [skt_pkg::KEY_W-1:0]    key_i,
  input  logic        [skt_pkg::PRICE_W-1:0]  price_cents_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [skt_pkg::STAT_W-1:0]   status_o,
  output logic signed [skt_pkg::KEY_W-1:0]    found_key_o,
  output logic        [skt_pkg::PRICE_W-1:0]  found_price_o,
  output logic        [skt_pkg::CNT_W-1:0]    entry_total_o,
  output logic                                last_o
);
  import skt_pkg::*;

  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_LIST = 3'd3;

  logic [2:0]                state_q, state_d;
  logic [CMD_W-1:0]          cmd_q;
  logic signed [KEY_W-1:0]   key_q;
  logic [PRICE_W-1:0]        price_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          idx_q, idx_d;

  logic                      out_valid_q, out_valid_d;
  logic [STAT_W-1:0]         status_q, status_d;
  logic signed [KEY_W-1:0]   okey_q, okey_d;
  logic [PRICE_W-1:0]        oprice_q, oprice_d;
  logic [CNT_W-1:0]          total_q, total_d;
  logic                      last_q, last_d;

  cell_ctl_t                 ctl;
  logic signed [KEY_W-1:0]   key_w   [DEPTH];
  logic [PRICE_W-1:0]        price_w [DEPTH];
  logic                      upper_w [DEPTH];
  logic [DEPTH-1:0]          eq_w;
  logic                      any_eq, out_free, in_acc, list_end;
  logic [PRICE_W-1:0]        hit_price;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign any_eq   = |eq_w;
  assign list_end = (idx_q + 1'b1) == count_q;

  // Select the price of the matching cell
  always_comb begin
    hit_price = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_price = hit_price | (eq_w[i] ? price_w[i] : '0);
    end
  end

  // Cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [KEY_W-1:0] pk, nk;
    logic [PRICE_W-1:0]      pp, np;
    logic                    pu;
    if (g == 0) begin : g_head
      assign pk = '0;
      assign pp = '0;
      assign pu = 1'b0;
    end else begin : g_mid
      assign pk = key_w[g-1];
      assign pp = price_w[g-1];
      assign pu = upper_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign nk = '0;
      assign np = '0;
    end else begin : g_nxt
      assign nk = key_w[g+1];
      assign np = price_w[g+1];
    end
    skt_cell #(.IDX(g)) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .prev_key_i   (pk),
      .prev_price_i (pp),
      .prev_upper_i (pu),
      .next_key_i   (nk),
      .next_price_i (np),
      .head_key_i   (key_w[0]),
      .head_price_i (price_w[0]),
      .key_o        (key_w[g]),
      .price_o      (price_w[g]),
      .upper_o      (upper_w[g]),
      .eq_o         (eq_w[g])
    );
  end

  // Sequence the command and build each result
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    okey_d      = okey_q;
    oprice_d    = oprice_q;
    total_d     = total_q;
    last_d      = last_q;
    ctl.op      = OP_HOLD;
    ctl.cmp     = state_q == S_CMP;
    ctl.key     = key_q;
    ctl.price   = price_q;
    ctl.count   = count_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_d  = S_IDLE;
          okey_d   = key_q;
          oprice_d = '0;
          last_d   = 1'b1;
          case (cmd_q)
            CMD_INSERT: begin
              if (count_q >= DepthCnt) begin
                status_d = ST_FULL;
              end else if (any_eq) begin
                status_d = ST_DUP;
              end else begin
                status_d = ST_OK;
                oprice_d = price_q;
                count_d  = count_q + 1'b1;
                ctl.op   = OP_INSERT;
              end
            end
            CMD_REMOVE, CMD_SEARCH: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (!any_eq) begin
                status_d = ST_MISSING;
              end else begin
                status_d = ST_OK;
                oprice_d = hit_price;
                if (cmd_q == CMD_REMOVE) begin
                  count_d = count_q - 1'b1;
                  ctl.op  = OP_REMOVE;
                end
              end
            end
            default: begin
              status_d = ST_EMPTY;
              okey_d   = '0;
            end
          endcase
          total_d     = count_d;
          out_valid_d = 1'b1;
          // A non-empty list emits from its own loop
          if (cmd_q == CMD_LIST && count_q != '0) begin
            out_valid_d = 1'b0;
            idx_d       = '0;
            state_d     = S_LIST;
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          okey_d      = key_w[0];
          oprice_d    = price_w[0];
          total_d     = count_q;
          last_d      = list_end;
          ctl.op      = OP_ROTATE;
          idx_d       = idx_q + 1'b1;
          if (list_end) state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= command_i;
      key_q   <= key_i;
      price_q <= price_cents_i;
    end
    status_q <= status_d;
    okey_q   <= okey_d;
    oprice_q <= oprice_d;
    total_q  <= total_d;
    last_q   <= last_d;
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_key_o   = okey_q;
  assign found_price_o = oprice_q;
  assign entry_total_o = total_q;
  assign last_o        = last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count beyond table depth");

  a_accept_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_CMP)
    else $error("accepted request did not enter compare");

  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> $onehot0(eq_w))
    else $error("key matched in more than one cell");

  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIST |-> count_q != '0 && idx_q < count_q)
    else $error("list walk outside the filled cells");

endmodule

// ===== sim/tb_sorted_key_table.sv =====
module tb_sorted_key_table;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 7;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 20;
  localparam int RUN_LIMIT_CYCLES = 300000;
  localparam int RANDOM_REQUESTS = 100;
  localparam int MAX_REPORTS = 10;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic        [STAT_W-1:0]  status;
    logic signed [KEY_W-1:0]   key;
    logic        [PRICE_W-1:0] price;
    logic        [CNT_W-1:0]   total;
    logic                      last;
  } table_reply_t;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic        [CMD_W-1:0]     command_i = CMD_INSERT;
  logic signed [KEY_W-1:0]     key_i = '0;
  logic        [PRICE_W-1:0]   price_cents_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic        [STAT_W-1:0]    status_o;
  logic signed [KEY_W-1:0]     found_key_o;
  logic        [PRICE_W-1:0]   found_price_o;
  logic        [CNT_W-1:0]     entry_total_o;
  logic                        last_o;

  // Shadow copy of the table and the replies still owed by the block
  logic signed [KEY_W-1:0]     shadow_key [TABLE_DEPTH];
  logic        [PRICE_W-1:0]   shadow_price [TABLE_DEPTH];
  int                          shadow_count = 0;
  table_reply_t                pending_replies [$];

  int                          mismatches = 0;
  bit                          quiet_mode = 1'b0;
  bit                          rx_hold_request = 1'b0;

  sorted_key_table #(
    .DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .key_i        (key_i),
    .price_cents_i(price_cents_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_key_o  (found_key_o),
    .found_price_o(found_price_o),
    .entry_total_o(entry_total_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Give up on a hung block
  initial begin
    #(RUN_LIMIT_CYCLES * CLK_PERIOD);
    $display("sorted_key_table: mismatch");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Queue one reply; the total is the entry count after the command
  function automatic void queue_reply(logic [STAT_W-1:0] status,
                                      logic signed [KEY_W-1:0] key,
                                      logic [PRICE_W-1:0] price, logic last);
    table_reply_t r;
    r.status = status;
    r.key    = key;
    r.price  = price;
    r.total  = CNT_W'(shadow_count);
    r.last   = last;
    pending_replies.push_back(r);
  endfunction

  // Apply one accepted request to the shadow table and queue its replies
  function automatic void predict_command(logic [CMD_W-1:0] cmd,
                                          logic signed [KEY_W-1:0] key,
                                          logic [PRICE_W-1:0] price);
    int pos;
    int i;
    logic [PRICE_W-1:0] stored;
    pos = 0;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          queue_reply(ST_FULL, key, '0, 1'b1);
        end else begin
          while (pos < shadow_count && shadow_key[pos] < key) pos++;
          if (pos < shadow_count && shadow_key[pos] == key) begin
            queue_reply(ST_DUP, key, '0, 1'b1);
          end else begin
            // open a slot by moving larger keys up
            for (i = shadow_count; i > pos; i--) begin
              shadow_key[i]   = shadow_key[i-1];
              shadow_price[i] = shadow_price[i-1];
            end
            shadow_key[pos]   = key;
            shadow_price[pos] = price;
            shadow_count++;
            queue_reply(ST_OK, key, price, 1'b1);
          end
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        if (shadow_count == 0) begin
          queue_reply(ST_EMPTY, key, '0, 1'b1);
        end else begin
          while (pos < shadow_count && shadow_key[pos] != key) pos++;
          if (pos == shadow_count) begin
            queue_reply(ST_MISSING, key, '0, 1'b1);
          end else begin
            stored = shadow_price[pos];
            if (cmd == CMD_REMOVE) begin
              // close the gap by moving later keys down
              for (i = pos; i + 1 < shadow_count; i++) begin
                shadow_key[i]   = shadow_key[i+1];
                shadow_price[i] = shadow_price[i+1];
              end
              shadow_count--;
            end
            queue_reply(ST_OK, key, stored, 1'b1);
          end
        end
      end
      default: begin
        if (shadow_count == 0) begin
          queue_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++)
            queue_reply(ST_OK, shadow_key[i], shadow_price[i], i == shadow_count - 1);
        end
      end
    endcase
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_stored_key();
    if (shadow_count == 0) return $urandom;
    return shadow_key[$urandom_range(0, shadow_count - 1)];
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_fresh_key();
    int near;
    if ($urandom_range(0, 1)) return $urandom;
    near = $urandom_range(0, 40);
    return near - 20;
  endfunction

  // Offer one request, hold it until accepted, then predict its replies
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic signed [KEY_W-1:0] key,
                              input logic [PRICE_W-1:0] price);
    int gap;
    if (!quiet_mode && $urandom_range(0, 1)) begin
      gap = pick_gap();
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    key_i         <= key;
    price_cents_i <= price;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_command(cmd, key, price);
  endtask

  // Stop offering until every owed reply is back
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall runs, plus a long hold when asked
  initial begin : receiver
    int run_left;
    int hold_left;
    bit stalling;
    run_left  = 0;
    hold_left = 0;
    stalling  = 1'b1;
    forever begin
      @(posedge clk_i);
      if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (quiet_mode) begin
        run_left = 0;
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          if (stalling) run_left = pick_gap();
          else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(40, 80);
          else run_left = $urandom_range(1, 16);
        end
        run_left--;
        out_stall_i <= stalling;
      end
    end
  end

  // Compare each accepted reply with the oldest one owed
  always @(posedge clk_i) begin : check_replies
    table_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch($sformatf(
          "unexpected reply: status %0d key %0d price %0d total %0d last %0b",
          status_o, found_key_o, found_price_o, entry_total_o, last_o));
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status || found_key_o !== want.key ||
            found_price_o !== want.price || entry_total_o !== want.total ||
            last_o !== want.last) begin
          flag_mismatch($sformatf({"reply differs: expected status %0d key %0d price %0d ",
            "total %0d last %0b, got status %0d key %0d price %0d total %0d last %0b"},
            want.status, want.key, want.price, want.total, want.last,
            status_o, found_key_o, found_price_o, entry_total_o, last_o));
        end
      end
    end
  end

  // Remove, search and list while nothing is stored
  task automatic test_empty_table();
    send_request(CMD_REMOVE, KEY_MIN, 32'hFFFF_FFFF);
    send_request(CMD_SEARCH, KEY_MAX, '0);
    send_request(CMD_LIST, -1, $urandom);
  endtask

  // Key extremes, ordering across zero, duplicates, misses, first and last entries
  task automatic test_basic_ops();
    send_request(CMD_INSERT, 0, 32'd100);
    send_request(CMD_INSERT, KEY_MAX, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, KEY_MIN, '0);
    send_request(CMD_INSERT, -1, 32'd5);
    send_request(CMD_INSERT, 1, $urandom);
    send_request(CMD_INSERT, 0, 32'd7);
    send_request(CMD_SEARCH, KEY_MIN, $urandom);
    send_request(CMD_SEARCH, 2, '0);
    send_request(CMD_LIST, 0, '0);
    send_request(CMD_REMOVE, -1, '0);
    send_request(CMD_REMOVE, 3, '0);
    send_request(CMD_REMOVE, KEY_MAX, '0);
    send_request(CMD_REMOVE, KEY_MIN, '0);
    send_request(CMD_LIST, KEY_MAX, 32'hFFFF_FFFF);
    send_request(CMD_SEARCH, 0, '0);
    send_request(CMD_REMOVE, 0, '0);
    send_request(CMD_REMOVE, 1, '0);
  endtask

  // Fill every slot, hit the full case, list it all, then empty it again
  task automatic test_full_table();
    int i;
    int fill_key;
    i = 0;
    while (shadow_count < TABLE_DEPTH) begin
      fill_key = (i % 2 == 1) ? -(i * 977) : i * 977 + 5;
      send_request(CMD_INSERT, fill_key, $urandom);
      i++;
    end
    send_request(CMD_INSERT, pick_stored_key(), $urandom);
    send_request(CMD_INSERT, KEY_MAX, $urandom);
    send_request(CMD_SEARCH, pick_stored_key(), '0);
    send_request(CMD_LIST, '0, '0);
    while (shadow_count > 0) send_request(CMD_REMOVE, pick_stored_key(), $urandom);
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_output_hold();
    int i;
    rx_hold_request = 1'b1;
    for (i = 0; i < 8; i++) send_request(CMD_INSERT, pick_fresh_key(), $urandom);
    send_request(CMD_LIST, '0, '0);
    send_request(CMD_SEARCH, pick_stored_key(), '0);
  endtask

  // Pause the sender until the block has answered everything
  task automatic test_sender_pause();
    send_request(CMD_INSERT, pick_fresh_key(), $urandom);
    drain_replies();
    send_request(CMD_SEARCH, pick_stored_key(), '0);
    send_request(CMD_LIST, '0, '0);
    drain_replies();
    send_request(CMD_REMOVE, pick_stored_key(), '0);
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_quiet_stream();
    int i;
    quiet_mode = 1'b1;
    for (i = 0; i < 6; i++) send_request(CMD_INSERT, pick_fresh_key(), $urandom);
    send_request(CMD_LIST, '0, '0);
    for (i = 0; i < 4; i++) send_request(CMD_SEARCH, pick_stored_key(), '0);
    for (i = 0; i < 4; i++) send_request(CMD_REMOVE, pick_stored_key(), '0);
    quiet_mode = 1'b0;
  endtask

  // Mostly well-formed traffic on stored keys, with misses and duplicates mixed in
  task automatic test_random_traffic();
    int n;
    int r;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40 && shadow_count < 24) send_request(CMD_INSERT, pick_fresh_key(), $urandom);
      else if (r < 55) send_request(CMD_REMOVE, pick_stored_key(), $urandom);
      else if (r < 75) send_request(CMD_SEARCH, pick_stored_key(), $urandom);
      else if (r < 83) send_request(CMD_LIST, $urandom, $urandom);
      else if (r < 88) send_request(CMD_INSERT, pick_stored_key(), $urandom);
      else if (r < 94) send_request(CMD_REMOVE, $urandom, $urandom);
      else send_request(CMD_SEARCH, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_basic_ops();
    test_full_table();
    test_output_hold();
    test_sender_pause();
    test_quiet_stream();
    test_random_traffic();

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_replies.size() != 0)
      flag_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));

    if (mismatches == 0) begin
      $display("sorted_key_table: match");
    end else begin
      $display("sorted_key_table: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/skt_pkg.sv
hdl/skt_cell.sv
hdl/sorted_key_table.sv
sim/tb_sorted_key_table.sv
